>>> sv/cwf_pkg.sv
// Shared widths, calendar constants and types for the calendar week fields core.
// No dependencies; compiled first.
package cwf_pkg;

    localparam int DAY_W   = 23;
    localparam int Z_W     = 22;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int WEEK_W  = 6;
    localparam int YDAY_W  = 9;
    localparam int PACK_W  = 20;

    // first day 0001-01-01, last day 9999-12-31, shift to a 0000-03-01 origin
    localparam logic signed [DAY_W-1:0] DAY_MIN     = -23'sd719162;
    localparam logic signed [DAY_W-1:0] DAY_MAX     = 23'sd2932896;
    localparam logic signed [DAY_W-1:0] EPOCH_SHIFT = 23'sd719468;

    // days in a 400-year Gregorian cycle
    localparam logic [17:0] ERA_DAYS = 18'd146097;

    // pipeline layout: 3 front stages, 6 civil stages, 2 back stages
    localparam int PIPE_DEPTH = 11;
    localparam int CIV_FIRST  = 3;
    localparam int CIV_DEPTH  = 6;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [YDAY_W-1:0]  yday;
        logic               leap;
    } t_civil;

endpackage

>>> sv/cwf_if.sv
// Valid/ready channel interfaces for date items and week-field results.
// Depends on cwf_pkg.
interface cwf_in_if;
    import cwf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DAY_W-1:0]  day_number;
    logic                     is_missing;

    modport source (output valid, output day_number, output is_missing, input ready);
    modport sink   (input valid, input day_number, input is_missing, output ready);
endinterface

interface cwf_out_if;
    import cwf_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [YEAR_W-1:0]  iso_year;
    logic [WEEK_W-1:0]  iso_week;
    logic [WEEK_W-1:0]  block_week;
    logic [PACK_W-1:0]  iso_year_week;
    logic [PACK_W-1:0]  block_year_week;
    logic [PACK_W-1:0]  year_month;
    logic               leap_year;

    modport source (
        output valid, output valid_res, output cal_year, output cal_month,
        output iso_year, output iso_week, output block_week, output iso_year_week,
        output block_year_week, output year_month, output leap_year,
        input  ready
    );
    modport sink (
        input  valid, input valid_res, input cal_year, input cal_month,
        input  iso_year, input iso_week, input block_week, input iso_year_week,
        input  block_year_week, input year_month, input leap_year,
        output ready
    );
endinterface

>>> sv/cwf_civil.sv
// Six-stage pipeline: day count from 0000-03-01 to year, month, day of year, leap flag.
// Depends on cwf_pkg; stage enables come from the top-level pipeline control.
module cwf_civil (
    input  logic                            i_clk,
    input  logic [cwf_pkg::CIV_DEPTH-1:0]   i_en,
    input  logic [cwf_pkg::Z_W-1:0]         i_z,
    output cwf_pkg::t_civil                 o_civ
);
    import cwf_pkg::*;

    // reciprocals: floor(x/d) == (x*M) >> K whenever xmax*d < 2^K
    localparam int          K_ERA  = 40;
    localparam logic [22:0] M_ERA  = 23'((64'd1 << K_ERA) / 64'd146097 + 64'd1);
    localparam int          K_1460 = 28;
    localparam logic [17:0] M_1460 = 18'((64'd1 << K_1460) / 64'd1460 + 64'd1);
    localparam int          K_CENT = 33;
    localparam logic [17:0] M_CENT = 18'((64'd1 << K_CENT) / 64'd36524 + 64'd1);
    localparam int          K_365  = 26;
    localparam logic [17:0] M_365  = 18'((64'd1 << K_365) / 64'd365 + 64'd1);
    localparam int          K_153  = 19;
    localparam logic [11:0] M_153  = 12'((64'd1 << K_153) / 64'd153 + 64'd1);

    localparam logic [17:0] LAST_DOE   = ERA_DAYS - 18'd1;
    localparam logic [3:0]  MP_JAN     = 4'd10;     // March-based month index of January
    localparam logic [8:0]  JAN1_DOY   = 9'd305;    // March-based day of 31 December, prior year
    localparam logic [8:0]  MAR1_YDAY  = 9'd60;     // day of year of 1 March, common year

    // stage 1: era
    logic [44:0]    s_era_prod;
    logic [4:0]     r_era1;
    logic [Z_W-1:0] r_z1;

    assign s_era_prod = 45'(i_z) * 45'(M_ERA);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_era1 <= s_era_prod[K_ERA+4:K_ERA];
            r_z1   <= i_z;
        end
    end

    // stage 2: day of era
    logic [Z_W-1:0] s_era_days;
    logic [17:0]    n_doe2;
    logic [17:0]    r_doe2;
    logic [4:0]     r_era2;

    assign s_era_days = 22'(r_era1) * 22'(ERA_DAYS);
    assign n_doe2     = 18'(r_z1 - s_era_days);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_doe2 <= n_doe2;
            r_era2 <= r_era1;
        end
    end

    // stage 3: leap-day corrections before the year divide
    logic [35:0] s_p1460;
    logic [35:0] s_pcent;
    logic [6:0]  s_n4;
    logic [2:0]  s_n100;
    logic [17:0] n_t3;
    logic [17:0] r_t3;
    logic [17:0] r_doe3;
    logic [4:0]  r_era3;

    assign s_p1460 = 36'(r_doe2) * 36'(M_1460);
    assign s_pcent = 36'(r_doe2) * 36'(M_CENT);
    assign s_n4    = s_p1460[K_1460+6:K_1460];
    assign s_n100  = s_pcent[K_CENT+2:K_CENT];
    assign n_t3    = r_doe2 - 18'(s_n4) + 18'(s_n100) - 18'(r_doe2 == LAST_DOE);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_t3   <= n_t3;
            r_doe3 <= r_doe2;
            r_era3 <= r_era2;
        end
    end

    // stage 4: year of era
    logic [35:0] s_p365;
    logic [8:0]  r_yoe4;
    logic [17:0] r_doe4;
    logic [4:0]  r_era4;

    assign s_p365 = 36'(r_t3) * 36'(M_365);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_yoe4 <= s_p365[K_365+8:K_365];
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
        end
    end

    // stage 5: March-based day of year
    logic [1:0]  s_cent;
    logic [17:0] s_base;
    logic [8:0]  n_doy5;
    logic [8:0]  r_doy5;
    logic [8:0]  r_yoe5;
    logic [4:0]  r_era5;

    assign s_cent = 2'(r_yoe4 >= 9'd100) + 2'(r_yoe4 >= 9'd200) + 2'(r_yoe4 >= 9'd300);
    assign s_base = 18'(r_yoe4) * 18'd365 + 18'(r_yoe4[8:2]) - 18'(s_cent);
    assign n_doy5 = 9'(r_doe4 - s_base);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_doy5 <= n_doy5;
            r_yoe5 <= r_yoe4;
            r_era5 <= r_era4;
        end
    end

    // stage 6: month, calendar year, January-based day of year, leap flag
    logic [10:0] s_x;
    logic [22:0] s_pmp;
    logic [3:0]  s_mp;
    logic        s_jan_feb;
    logic [8:0]  s_yy;
    logic        s_leap;
    t_civil      n_civ;
    t_civil      r_civ;

    always_comb begin
        s_x       = 11'(r_doy5) * 11'd5 + 11'd2;
        s_pmp     = 23'(s_x) * 23'(M_153);
        s_mp      = s_pmp[K_153+3:K_153];
        s_jan_feb = (s_mp >= MP_JAN);
        // year within the cycle; 0 and 400 are multiples of 400
        s_yy      = r_yoe5 + 9'(s_jan_feb);
        s_leap    = (s_yy[1:0] == 2'd0) && (s_yy != 9'd100) && (s_yy != 9'd200)
                    && (s_yy != 9'd300);
        n_civ.year  = 14'(r_era5) * 14'd400 + 14'(s_yy);
        n_civ.month = s_jan_feb ? (s_mp - 4'd9) : (s_mp + 4'd3);
        n_civ.yday  = s_jan_feb ? (r_doy5 - JAN1_DOY)
                                : (r_doy5 + MAR1_YDAY + 9'(s_leap));
        n_civ.leap  = s_leap;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_civ <= n_civ;
        end
    end

    assign o_civ = r_civ;

endmodule

>>> sv/calendar_week_fields_core.sv
// Top level of the calendar / ISO 8601 week fields core: pipeline control,
// front and back stages, two civil-date pipelines. Depends on cwf_pkg, cwf_if, cwf_civil.
//
// Eleven register stages from input transfer to result valid.
// Throughput: one item per cycle, held only when the pipeline is full and the sink stalls.
// Reset (i_rst_n low, synchronous) empties the pipeline; data registers are not reset.
module calendar_week_fields_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cwf_in_if.sink    i_item,
    cwf_out_if.source o_res
);
    import cwf_pkg::*;

    // floor(x/7) for the weekday and for week numbers
    localparam int          K_WD7 = 25;
    localparam logic [22:0] M_WD7 = 23'((64'd1 << K_WD7) / 64'd7 + 64'd1);
    localparam int          K_WK7 = 12;
    localparam logic [9:0]  M_WK7 = 10'((64'd1 << K_WK7) / 64'd7 + 64'd1);

    localparam int LAST = PIPE_DEPTH - 1;

    // ---------------------------------------------------------------
    // Pipeline control: each stage loads when it is empty or the stage
    // after it moves, so bubbles squeeze out and a stall holds every item.
    // ---------------------------------------------------------------
    logic [PIPE_DEPTH:0]   s_rdy;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [LAST-1:0]       r_miss;

    always_comb begin
        s_rdy[PIPE_DEPTH] = o_res.ready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            s_rdy[k] = !r_vld[k] || s_rdy[k+1];
        end
    end

    assign i_item.ready = s_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_rdy[0]) begin
                r_vld[0] <= i_item.valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (s_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // missing flag rides along with each item up to the output stage
    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r_miss[0] <= i_item.is_missing;
        end
        for (int k = 1; k < LAST; k++) begin
            if (s_rdy[k]) begin
                r_miss[k] <= r_miss[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: clamp to 0001-01-01 .. 9999-12-31 and move origin to 0000-03-01
    // ---------------------------------------------------------------
    logic signed [DAY_W-1:0] s_day_c;
    logic signed [DAY_W-1:0] s_z_sum;
    logic [Z_W-1:0]          r_z0;

    always_comb begin
        priority if (i_item.day_number < DAY_MIN) begin
            s_day_c = DAY_MIN;
        end else if (i_item.day_number > DAY_MAX) begin
            s_day_c = DAY_MAX;
        end else begin
            s_day_c = i_item.day_number;
        end
        s_z_sum = s_day_c + EPOCH_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r_z0 <= s_z_sum[Z_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: (z + 2) / 7 - Monday-based weekday is (z + 2) mod 7
    // ---------------------------------------------------------------
    logic [Z_W-1:0] s_zp2;
    logic [44:0]    s_wd_prod;
    logic [Z_W-1:0] r_zp2_1;
    logic [Z_W-1:0] r_z1;
    logic [18:0]    r_q7_1;

    assign s_zp2     = r_z0 + 22'd2;
    assign s_wd_prod = 45'(s_zp2) * 45'(M_WD7);

    always_ff @(posedge i_clk) begin
        if (s_rdy[1]) begin
            r_zp2_1 <= s_zp2;
            r_z1    <= r_z0;
            r_q7_1  <= s_wd_prod[K_WD7+18:K_WD7];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: Thursday of the same Monday-based week
    // ---------------------------------------------------------------
    logic [2:0]     s_iso_wd;
    logic [Z_W-1:0] r_z2;
    logic [Z_W-1:0] r_thu2;

    assign s_iso_wd = 3'(r_zp2_1 - 22'(r_q7_1) * 22'd7);

    always_ff @(posedge i_clk) begin
        if (s_rdy[2]) begin
            r_z2   <= r_z1;
            r_thu2 <= r_z1 + 22'd3 - 22'(s_iso_wd);
        end
    end

    // ---------------------------------------------------------------
    // Stages 3..8: civil date of the day itself and of its Thursday
    // ---------------------------------------------------------------
    t_civil s_civ_day;
    t_civil s_civ_thu;

    cwf_civil u_civil_day (
        .i_clk (i_clk),
        .i_en  (s_rdy[CIV_FIRST+CIV_DEPTH-1:CIV_FIRST]),
        .i_z   (r_z2),
        .o_civ (s_civ_day)
    );

    cwf_civil u_civil_thu (
        .i_clk (i_clk),
        .i_en  (s_rdy[CIV_FIRST+CIV_DEPTH-1:CIV_FIRST]),
        .i_z   (r_thu2),
        .o_civ (s_civ_thu)
    );

    // ---------------------------------------------------------------
    // Stage 9: week numbers, 1 + (day of year - 1) / 7
    // ---------------------------------------------------------------
    function automatic logic [WEEK_W-1:0] f_week(input logic [YDAY_W-1:0] yday);
        logic [18:0] prod;
        prod = 19'(yday - 9'd1) * 19'(M_WK7);
        return prod[K_WK7+WEEK_W-1:K_WK7] + 6'd1;
    endfunction

    logic [YEAR_W-1:0]  r_year9;
    logic [MONTH_W-1:0] r_month9;
    logic               r_leap9;
    logic [YEAR_W-1:0]  r_iyear9;
    logic [WEEK_W-1:0]  r_bw9;
    logic [WEEK_W-1:0]  r_iw9;

    always_ff @(posedge i_clk) begin
        if (s_rdy[9]) begin
            r_year9  <= s_civ_day.year;
            r_month9 <= s_civ_day.month;
            r_leap9  <= s_civ_day.leap;
            r_iyear9 <= s_civ_thu.year;
            r_bw9    <= f_week(s_civ_day.yday);
            r_iw9    <= f_week(s_civ_thu.yday);
        end
    end

    // ---------------------------------------------------------------
    // Stage 10: packings and output register; a missing date reads as zeros
    // ---------------------------------------------------------------
    logic               r_o_valid_res;
    logic [YEAR_W-1:0]  r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [YEAR_W-1:0]  r_o_iyear;
    logic [WEEK_W-1:0]  r_o_iw;
    logic [WEEK_W-1:0]  r_o_bw;
    logic [PACK_W-1:0]  r_o_iyw;
    logic [PACK_W-1:0]  r_o_byw;
    logic [PACK_W-1:0]  r_o_ym;
    logic               r_o_leap;

    always_ff @(posedge i_clk) begin
        if (s_rdy[LAST]) begin
            if (r_miss[LAST-1]) begin
                r_o_valid_res <= 1'b0;
                r_o_year      <= '0;
                r_o_month     <= '0;
                r_o_iyear     <= '0;
                r_o_iw        <= '0;
                r_o_bw        <= '0;
                r_o_iyw       <= '0;
                r_o_byw       <= '0;
                r_o_ym        <= '0;
                r_o_leap      <= 1'b0;
            end else begin
                r_o_valid_res <= 1'b1;
                r_o_year      <= r_year9;
                r_o_month     <= r_month9;
                r_o_iyear     <= r_iyear9;
                r_o_iw        <= r_iw9;
                r_o_bw        <= r_bw9;
                r_o_iyw       <= 20'(r_iyear9) * 20'd100 + 20'(r_iw9);
                r_o_byw       <= 20'(r_year9) * 20'd100 + 20'(r_bw9);
                r_o_ym        <= 20'(r_year9) * 20'd100 + 20'(r_month9);
                r_o_leap      <= r_leap9;
            end
        end
    end

    assign o_res.valid           = r_vld[LAST];
    assign o_res.valid_res       = r_o_valid_res;
    assign o_res.cal_year        = r_o_year;
    assign o_res.cal_month       = r_o_month;
    assign o_res.iso_year        = r_o_iyear;
    assign o_res.iso_week        = r_o_iw;
    assign o_res.block_week      = r_o_bw;
    assign o_res.iso_year_week   = r_o_iyw;
    assign o_res.block_year_week = r_o_byw;
    assign o_res.year_month      = r_o_ym;
    assign o_res.leap_year       = r_o_leap;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------

    // input back-pressure only when every stage holds an item and the sink stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled with room in the pipeline");

    // a missing date gives an all-zero result
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.valid_res) |->
            (o_res.cal_year == '0 && o_res.cal_month == '0 && o_res.iso_year == '0 &&
             o_res.iso_week == '0 && o_res.block_week == '0 && o_res.year_month == '0 &&
             o_res.iso_year_week == '0 && o_res.block_year_week == '0 && !o_res.leap_year))
        else $error("missing date gave non-zero fields");

    // decoded fields stay in their calendar ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.valid_res) |->
            (o_res.cal_month >= 4'd1 && o_res.cal_month <= 4'd12 &&
             o_res.cal_year >= 14'd1 && o_res.cal_year <= 14'd9999 &&
             o_res.iso_week >= 6'd1 && o_res.iso_week <= 6'd53 &&
             o_res.block_week >= 6'd1 && o_res.block_week <= 6'd53))
        else $error("decoded field out of range");

    // the Thursday of a week is never more than a year boundary away
    a_iso_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.valid_res) |->
            (o_res.iso_year == o_res.cal_year ||
             o_res.iso_year == o_res.cal_year + 14'd1 ||
             o_res.iso_year + 14'd1 == o_res.cal_year))
        else $error("ISO year too far from calendar year");

endmodule

>>> dv/calendar_week_fields_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the calendar week fields core, predicts every result
// from the date transfers and compares field by field. Depends on cwf_pkg, cwf_if.
module calendar_week_fields_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cwf_in_if    i_item,
    cwf_out_if   i_res,
    output int   o_errors,
    output int   o_pending
);
    import cwf_pkg::*;

    typedef struct packed {
        logic               valid_res;
        logic [YEAR_W-1:0]  cal_year;
        logic [MONTH_W-1:0] cal_month;
        logic [YEAR_W-1:0]  iso_year;
        logic [WEEK_W-1:0]  iso_week;
        logic [WEEK_W-1:0]  block_week;
        logic [PACK_W-1:0]  iso_year_week;
        logic [PACK_W-1:0]  block_year_week;
        logic [PACK_W-1:0]  year_month;
        logic               leap_year;
    } t_week_fields;

    t_week_fields fields_due[$];
    int           mismatch_cnt = 0;

    assign o_errors = mismatch_cnt;

    function automatic int unsigned gregorian_leap(input int unsigned yr);
        return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 1 : 0;
    endfunction

    // days before the first of a month in a common year, leap day added after February
    function automatic int unsigned ordinal_day(input int unsigned yr, input int unsigned mon,
                                                input int unsigned dom);
        int unsigned prior_days;
        case (mon)
            1:       prior_days = 0;
            2:       prior_days = 31;
            3:       prior_days = 59;
            4:       prior_days = 90;
            5:       prior_days = 120;
            6:       prior_days = 151;
            7:       prior_days = 181;
            8:       prior_days = 212;
            9:       prior_days = 243;
            10:      prior_days = 273;
            11:      prior_days = 304;
            12:      prior_days = 334;
            default: prior_days = 0;
        endcase
        if (mon > 2)
            prior_days += gregorian_leap(yr);
        return prior_days + dom;
    endfunction

    // zd counts days from 0000-03-01; years run March to February internally
    function automatic void civil_from_march_days(input int unsigned zd, output int unsigned yr,
                                                  output int unsigned mon, output int unsigned dom);
        int unsigned cycle, cday, cyear, mday, mslot;
        cycle = zd / 146097;
        cday  = zd - cycle * 146097;
        cyear = (cday - cday / 1460 + cday / 36524 - cday / 146096) / 365;
        mday  = cday - (365 * cyear + cyear / 4 - cyear / 100);
        mslot = (5 * mday + 2) / 153;
        dom   = mday - (153 * mslot + 2) / 5 + 1;
        mon   = (mslot < 10) ? mslot + 3 : mslot - 9;
        yr    = cyear + cycle * 400 + ((mon <= 2) ? 1 : 0);
    endfunction

    function automatic t_week_fields week_fields_of(input logic signed [DAY_W-1:0] day_in,
                                                    input logic missing);
        t_week_fields f;
        int           day;
        int unsigned  zd, yr, mon, dom, bweek, monday_idx, thu_zd, t_yr, t_mon, t_dom, iweek;
        f = '0;
        if (missing)
            return f;
        day = day_in;
        if (day < int'(DAY_MIN))
            day = int'(DAY_MIN);
        if (day > int'(DAY_MAX))
            day = int'(DAY_MAX);
        zd = day + int'(EPOCH_SHIFT);
        civil_from_march_days(zd, yr, mon, dom);
        bweek = (ordinal_day(yr, mon, dom) - 1) / 7 + 1;
        // zd = 0 was a Wednesday; Thursday of the Monday-based week fixes the ISO year
        monday_idx = ((zd + 3) % 7 + 6) % 7;
        thu_zd     = zd + 3 - monday_idx;
        civil_from_march_days(thu_zd, t_yr, t_mon, t_dom);
        iweek = 1 + (ordinal_day(t_yr, t_mon, t_dom) - 1) / 7;

        f.valid_res       = 1'b1;
        f.cal_year        = YEAR_W'(yr);
        f.cal_month       = MONTH_W'(mon);
        f.iso_year        = YEAR_W'(t_yr);
        f.iso_week        = WEEK_W'(iweek);
        f.block_week      = WEEK_W'(bweek);
        f.iso_year_week   = PACK_W'(t_yr * 100 + iweek);
        f.block_year_week = PACK_W'(yr * 100 + bweek);
        f.year_month      = PACK_W'(yr * 100 + mon);
        f.leap_year       = gregorian_leap(yr) ? 1'b1 : 1'b0;
        return f;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_week_fields want, got;
        if (i_rst_n) begin
            if (i_item.valid && i_item.ready)
                fields_due.push_back(week_fields_of(i_item.day_number, i_item.is_missing));
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.valid_res, i_res.cal_year, i_res.cal_month, i_res.iso_year,
                        i_res.iso_week, i_res.block_week, i_res.iso_year_week,
                        i_res.block_year_week, i_res.year_month, i_res.leap_year};
                if (fields_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                end else begin
                    want = fields_due.pop_front();
                    check_field("valid_res", want.valid_res, got.valid_res);
                    check_field("cal_year", want.cal_year, got.cal_year);
                    check_field("cal_month", want.cal_month, got.cal_month);
                    check_field("iso_year", want.iso_year, got.iso_year);
                    check_field("iso_week", want.iso_week, got.iso_week);
                    check_field("block_week", want.block_week, got.block_week);
                    check_field("iso_year_week", want.iso_year_week, got.iso_year_week);
                    check_field("block_year_week", want.block_year_week, got.block_year_week);
                    check_field("year_month", want.year_month, got.year_month);
                    check_field("leap_year", want.leap_year, got.leap_year);
                end
            end
        end
        o_pending <= fields_due.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the calendar week fields regression: clock, reset, date stimulus and
// result back-pressure. Depends on cwf_pkg, cwf_if, the core and its checker.
module testbench;
    import cwf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_DATES = 700;
    localparam int DRAIN_CYCLES = 40;   // pipeline is 11 deep, plus a receiver stall
    localparam int HOLD_CYCLES = 120;   // long receiver hold-off, well past pipeline depth

    // day numbers of interest
    localparam int FIRST_DAY = -719162;       // 0001-01-01, a Monday
    localparam int LAST_DAY  = 2932896;       // 9999-12-31, a Friday
    localparam int SPAN      = LAST_DAY - FIRST_DAY;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_cnt = 0;
    int   errors, pending;
    int   dates_sent = 0;
    int   results_taken = 0;

    cwf_in_if  date_ch ();
    cwf_out_if week_ch ();

    calendar_week_fields_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (date_ch),
        .o_res   (week_ch)
    );

    calendar_week_fields_checker u_week_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (date_ch),
        .i_res     (week_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #6 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sender idle gap per date. Dates 240..499 go back to back so that the
    // receiver hold-off below lands while the sender keeps offering.
    function automatic int sender_gap(input int idx);
        if (idx >= 240 && idx < 500)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // One date transfer. valid stays high across back-to-back dates, so it is
    // only dropped when a gap is wanted.
    task automatic send_date(input int day, input logic missing);
        int gap;
        gap = sender_gap(dates_sent);
        if (gap > 0) begin
            date_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        date_ch.valid      <= 1'b1;
        date_ch.day_number <= day[DAY_W-1:0];
        date_ch.is_missing <= missing;
        do @(posedge i_clk); while (!date_ch.ready);
        dates_sent++;
    endtask

    // Random date: mostly inside the calendar range, some anywhere in the
    // 23-bit field (out of range gets clamped), some around the range edges,
    // and some marked missing.
    function automatic int random_day();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return FIRST_DAY + int'($urandom_range(0, SPAN));
        if (pick < 85)
            return int'({{(32-DAY_W){1'b0}}, DAY_W'($urandom)}) - (1 << (DAY_W-1));
        if (pick < 92)
            return FIRST_DAY + int'($urandom_range(0, 20)) - 10;
        return LAST_DAY + int'($urandom_range(0, 20)) - 10;
    endfunction

    // Receiver: random stall before each result, none for results 500..599,
    // and one long hold-off once 250 results have arrived.
    initial begin
        int stall;
        week_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_taken == 250) begin
                week_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = (results_taken >= 500 && results_taken < 600) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                week_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            week_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!week_ch.valid);
            results_taken++;
        end
    end

    initial begin
        date_ch.valid      <= 1'b0;
        date_ch.day_number <= '0;
        date_ch.is_missing <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range edges, clamping, field extremes, missing dates,
        // leap days and ISO week boundaries
        send_date(FIRST_DAY, 1'b0);
        send_date(LAST_DAY, 1'b0);
        send_date(FIRST_DAY - 1, 1'b0);          // clamps up to 0001-01-01
        send_date(LAST_DAY + 1, 1'b0);           // clamps down to 9999-12-31
        send_date(-(1 << (DAY_W-1)), 1'b0);      // most negative field value
        send_date((1 << (DAY_W-1)) - 1, 1'b0);   // most positive field value
        send_date(0, 1'b0);                      // 1970-01-01
        send_date(-1, 1'b0);
        send_date(0, 1'b1);                      // missing: all zero
        send_date((1 << (DAY_W-1)) - 1, 1'b1);
        send_date(-(1 << (DAY_W-1)), 1'b1);
        send_date(11016, 1'b0);                  // 2000-02-29
        send_date(11322, 1'b0);                  // 2000-12-31, block week 53
        send_date(-25509, 1'b0);                 // 1900-02-28, not leap
        send_date(-25508, 1'b0);                 // 1900-03-01
        send_date(14242, 1'b0);                  // 2008-12-29, ISO week 1 of 2009
        send_date(18627, 1'b0);                  // 2020-12-31, ISO week 53
        send_date(18628, 1'b0);                  // 2021-01-01, still ISO 2020
        send_date(18631, 1'b0);                  // 2021-01-04, ISO week 1
        send_date(LAST_DAY - 4, 1'b0);           // 9999-12-27, Monday of last week
        send_date(FIRST_DAY + 6, 1'b0);          // 0001-01-07, end of first week

        for (int n = 0; n < RANDOM_DATES; n++) begin
            // sender waits here until the pipeline has fully drained
            if (n == 150) begin
                date_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send_date(random_day(), ($urandom_range(0, 9) == 0));
        end
        date_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
